// File: hdl/cop_pkg.sv
// Shared types, constants and helper functions for the circle octant point generator.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package cop_pkg;

	// Largest radius that still produces points.
	localparam int RADIUS_MAX = 1 << 8;

	// Widths of the square-root datapath: r*r for a 9-bit radius needs 18 bits.
	localparam int SQ_W = 18;

	// Digit-by-digit square root: nine steps, three per pipeline stage.
	localparam int SQRT_TOP   = 8;
	localparam int SQRT_STEPS = 3;

	// Eight symmetric points per column.
	localparam int POINTS = 8;
	localparam int IDX_W  = $clog2(POINTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);

	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [SQ_W-1:0] res;
	} sq_t;

	// One column after the square root, handed to the point serializer.
	typedef struct packed {
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic [8:0]         col;
		logic [8:0]         h;
	} item_t;

	// Serializer status, watched by the top level.
	typedef struct packed {
		logic             busy;
		logic [IDX_W-1:0] idx;
	} ser_stat_t;

	// How a point index maps to its offsets.
	typedef struct packed {
		logic swap;  // x takes h and y takes c
		logic xneg;
		logic yneg;
	} pt_sel_t;

	function automatic sq_t sqrt_step(sq_t cur, int s);
		logic [SQ_W-1:0] b;
		logic [SQ_W-1:0] t;
		sq_t             nxt;
		b = SQ_W'(1) << (2 * s);
		t = cur.res + b;
		if (cur.rem >= t) begin
			nxt.rem = cur.rem - t;
			nxt.res = (cur.res >> 1) + b;
		end else begin
			nxt.rem = cur.rem;
			nxt.res = cur.res >> 1;
		end
		return nxt;
	endfunction

	function automatic sq_t sqrt_stage(sq_t cur, int hi_step);
		sq_t acc;
		acc = cur;
		for (int k = 0; k < SQRT_STEPS; k++) begin
			acc = sqrt_step(acc, hi_step - k);
		end
		return acc;
	endfunction

	// Order: (c,h) (c,-h) (-c,h) (-c,-h) (h,c) (h,-c) (-h,c) (-h,-c).
	function automatic pt_sel_t point_sel(logic [IDX_W-1:0] idx);
		pt_sel_t sel;
		sel.swap = idx[2];
		sel.xneg = idx[1];
		sel.yneg = idx[0];
		return sel;
	endfunction

endpackage

`default_nettype wire

// File: hdl/cop_point_ser.sv
// Point serializer: expands one column into eight points behind an output register.
// Depends on cop_pkg for the item type, status type and the point ordering.
`default_nettype none

module cop_point_ser (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	input  wire cop_pkg::item_t      item,
	output logic                     item_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [16:0]       point_x,
	output logic signed [16:0]       point_y,
	output logic                     last_point,
	output cop_pkg::ser_stat_t       stat
);

	logic                         ser_valid_q;
	logic [cop_pkg::IDX_W-1:0]    idx_q;
	cop_pkg::item_t               item_q;
	logic                         out_valid_q;
	logic signed [16:0]           px_q;
	logic signed [16:0]           py_q;
	logic                         last_q;

	logic                         load_out;
	logic                         take;
	logic                         done;
	cop_pkg::pt_sel_t             sel;
	logic [8:0]                   off_x;
	logic [8:0]                   off_y;
	logic signed [16:0]           sx;
	logic signed [16:0]           sy;
	logic signed [16:0]           px_d;
	logic signed [16:0]           py_d;

	assign load_out   = !out_valid_q || out_ready;
	assign take       = ser_valid_q && load_out;
	assign done       = take && (idx_q == cop_pkg::LAST_IDX);
	assign item_ready = !ser_valid_q || done;

	always_comb begin
		sel   = cop_pkg::point_sel(idx_q);
		off_x = sel.swap ? item_q.h : item_q.col;
		off_y = sel.swap ? item_q.col : item_q.h;
		sx    = {item_q.cx[15], item_q.cx};
		sy    = {item_q.cy[15], item_q.cy};
		px_d  = sel.xneg ? sx - $signed({8'b0, off_x}) : sx + $signed({8'b0, off_x});
		py_d  = sel.yneg ? sy - $signed({8'b0, off_y}) : sy + $signed({8'b0, off_y});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (item_ready) begin
				ser_valid_q <= item_valid;
				idx_q       <= '0;
			end else if (take) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= ser_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_q <= item;
		end
		if (load_out) begin
			px_q   <= px_d;
			py_q   <= py_d;
			last_q <= (idx_q == cop_pkg::LAST_IDX);
		end
	end

	assign out_valid  = out_valid_q;
	assign point_x    = px_q;
	assign point_y    = py_q;
	assign last_point = last_q;
	assign stat.busy  = ser_valid_q;
	assign stat.idx   = idx_q;

endmodule

`default_nettype wire

// File: hdl/circle_octant_point_generator.sv
// Top level of the circle octant point generator: squaring, octant test, pipelined square root.
// Depends on cop_pkg and instantiates cop_point_ser for the eight-point output sequence.
`default_nettype none

//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+---------------------------
//  input   | center_x, center_y, radius, column        | in_valid && in_ready
//  output  | point_x, point_y, last_point              | out_valid && out_ready
//
// A column that lies inside the octant gives eight points, one per cycle while out_ready allows;
// a new column enters the serializer only with the last point of the one before.
// A column with zero radius, a radius above the maximum or 2*c*c > r*r gives no point and
// is dropped before stage 2, so such items are taken one per cycle unless stage 2 is stalled.
// With no stall, an input passes stages 1 to 5, the serializer's item register and its output
// register before out_valid rises.
// Reset (arst_n low) empties every stage at once. A stall on the output backs up stage by
// stage through per-stage ready signals; no item is lost or repeated.

module circle_octant_point_generator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] center_x,
	input  wire logic signed [15:0] center_y,
	input  wire logic [8:0]         radius,
	input  wire logic [8:0]         column,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [16:0]      point_x,
	output logic signed [16:0]      point_y,
	output logic                    last_point
);

	// Stage 1: registered inputs and the two squares.
	logic                          v_s1;
	logic signed [15:0]            cx_s1;
	logic signed [15:0]            cy_s1;
	logic [8:0]                    rad_s1;
	logic [8:0]                    col_s1;
	logic [cop_pkg::SQ_W-1:0]      rr_s1;
	logic [cop_pkg::SQ_W-1:0]      cc_s1;

	// Stage 2: octant test done, remainder r*r - c*c ready for the root.
	logic                          v_s2;
	logic signed [15:0]            cx_s2;
	logic signed [15:0]            cy_s2;
	logic [8:0]                    col_s2;
	cop_pkg::sq_t                  sq_s2;

	// Stages 3 to 5: three root steps each.
	logic                          v_s3;
	logic signed [15:0]            cx_s3;
	logic signed [15:0]            cy_s3;
	logic [8:0]                    col_s3;
	cop_pkg::sq_t                  sq_s3;

	logic                          v_s4;
	logic signed [15:0]            cx_s4;
	logic signed [15:0]            cy_s4;
	logic [8:0]                    col_s4;
	cop_pkg::sq_t                  sq_s4;

	logic                          v_s5;
	logic signed [15:0]            cx_s5;
	logic signed [15:0]            cy_s5;
	logic [8:0]                    col_s5;
	cop_pkg::sq_t                  sq_s5;

	logic                          rdy_s1;
	logic                          rdy_s2;
	logic                          rdy_s3;
	logic                          rdy_s4;
	logic                          rdy_s5;
	logic                          ser_ready;

	logic [cop_pkg::SQ_W-1:0]      rr_d;
	logic [cop_pkg::SQ_W-1:0]      cc_d;
	logic                          keep;
	cop_pkg::sq_t                  sq_in;
	cop_pkg::item_t                item;
	cop_pkg::ser_stat_t            ser_stat;

	// A stage takes new contents when it is empty or its contents move on.
	assign rdy_s5   = !v_s5 || ser_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign rr_d = {9'b0, radius} * {9'b0, radius};
	assign cc_d = {9'b0, column} * {9'b0, column};

	// The exact integer form of c <= r / sqrt(2) is 2*c*c <= r*r.
	assign keep = (rad_s1 != 9'd0)
		&& (rad_s1 <= 9'(cop_pkg::RADIUS_MAX))
		&& ({cc_s1, 1'b0} <= {1'b0, rr_s1});

	assign sq_in.rem = rr_s1 - cc_s1;
	assign sq_in.res = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1 && keep;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			cx_s1  <= center_x;
			cy_s1  <= center_y;
			rad_s1 <= radius;
			col_s1 <= column;
			rr_s1  <= rr_d;
			cc_s1  <= cc_d;
		end
		if (rdy_s2) begin
			cx_s2  <= cx_s1;
			cy_s2  <= cy_s1;
			col_s2 <= col_s1;
			sq_s2  <= sq_in;
		end
		if (rdy_s3) begin
			cx_s3  <= cx_s2;
			cy_s3  <= cy_s2;
			col_s3 <= col_s2;
			sq_s3  <= cop_pkg::sqrt_stage(sq_s2, cop_pkg::SQRT_TOP);
		end
		if (rdy_s4) begin
			cx_s4  <= cx_s3;
			cy_s4  <= cy_s3;
			col_s4 <= col_s3;
			sq_s4  <= cop_pkg::sqrt_stage(sq_s3, cop_pkg::SQRT_TOP - cop_pkg::SQRT_STEPS);
		end
		if (rdy_s5) begin
			cx_s5  <= cx_s4;
			cy_s5  <= cy_s4;
			col_s5 <= col_s4;
			sq_s5  <= cop_pkg::sqrt_stage(sq_s4,
				cop_pkg::SQRT_TOP - 2 * cop_pkg::SQRT_STEPS);
		end
	end

	assign item.cx  = cx_s5;
	assign item.cy  = cy_s5;
	assign item.col = col_s5;
	assign item.h   = sq_s5.res[8:0];

	cop_point_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (v_s5),
		.item       (item),
		.item_ready (ser_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.point_x    (point_x),
		.point_y    (point_y),
		.last_point (last_point),
		.stat       (ser_stat)
	);

	// The finished root of a kept column never exceeds the largest radius.
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (sq_s5.res <= cop_pkg::SQ_W'(cop_pkg::RADIUS_MAX)))
		else $error("square root result out of range");

	// A point index past the first only exists while the serializer holds a column.
	a_ser_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(ser_stat.idx != '0) |-> ser_stat.busy)
		else $error("serializer index advanced without a column");

	// A full stage that cannot move on keeps its item.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !rdy_s2) |=> v_s1)
		else $error("stage 1 item lost under stall");

endmodule

`default_nettype wire
